FILE: src/kslt_pkg.sv
// shared constants, codes and the table entry type for the keyed slot lock table
// no dependencies; used by every module of the block but kslt_ram
package kslt_pkg;

  localparam int DEPTH    = 64;
  localparam int POS_BITS = 16;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 7;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam int OP_W  = 3;
  localparam int ID_W  = 24;
  localparam int KEY_W = 16;
  localparam int STS_W = 3;
  localparam int EC_W  = 7;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_DUP       = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STS_W-1:0] STS_NONE      = 3'd3;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                lock;
    logic [ID_W-1:0]     grp;
    logic [ID_W-1:0]     nam;
    logic [POS_BITS-1:0] pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/kslt_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
module kslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/kslt_match.sv
// shared compare unit: checks one stored entry against the request of the current opcode
// depends on kslt_pkg
module kslt_match (
  input  logic [kslt_pkg::OP_W-1:0]     op,
  input  logic [kslt_pkg::ID_W-1:0]     grp,
  input  logic [kslt_pkg::ID_W-1:0]     nam,
  input  logic [kslt_pkg::POS_BITS-1:0] pos,
  input  kslt_pkg::entry_t              entry,
  output logic                          hit
);
  import kslt_pkg::*;

  logic id_eq;

  assign id_eq = (entry.grp == grp) && (entry.nam == nam);

  always_comb begin
    case (op)
      OP_ADD, OP_RELEASE: hit = id_eq && (entry.pos == pos);
      OP_ACQUIRE:         hit = id_eq && !entry.lock;
      default:            hit = 1'b0;
    endcase
  end

endmodule

FILE: src/keyed_slot_lock_table.sv
// Keyed slot lock table. One transaction in, one result out. Add, acquire and
// release walk the live entries (places 0 to count-1) through one ram read port
// and the shared compare unit, one entry per cycle with the compare in the cycle
// after the read, and stop at the first hit. Unlock all always walks every entry.
// Clear reads each live entry in turn and keeps a locked one; an unlocked one is
// overwritten with the last live entry, fetched through the ram port (or simply
// dropped when it is the last live one), and the entry now in its place is read next.
// No new transaction is taken until the result has been loaded into the output
// register. No clearing pass is needed after reset. max_entries may be written
// only while the block is idle.
// depends on kslt_pkg, kslt_ram and kslt_match
module keyed_slot_lock_table (
  input  logic                               clk,
  input  logic                               rst_n,
  // opcode, group_id, pool_name, key_pos (from bit 0 up), zero filled
  input  logic [kslt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // status, result_pos, entry_count (from bit 0 up), zero filled
  output logic [kslt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wr_en,
  input  logic [kslt_pkg::CFG_W-1:0]         cfg_wr_data
);
  import kslt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CL_RD = 3'd2;
  localparam logic [2:0] ST_CL_EV = 3'd3;
  localparam logic [2:0] ST_CL_MV = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     max_entries_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    ev_idx_r, ev_idx_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [ID_W-1:0]      grp_r, grp_nxt;
  logic [ID_W-1:0]      nam_r, nam_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [STS_W-1:0]     status_r, status_nxt;
  logic [KEY_W-1:0]     rpos_r, rpos_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  entry_t               ram_wdata, ram_rentry;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 hit;
  logic                 in_acc;
  logic                 full;
  logic [CMP_W-1:0]     cnt_ext, max_ext, cap;
  logic [31:0]          key_ext, rpos_ext;
  logic [CNT_W-1:0]     count_m1;

  assign ram_rentry = entry_t'(ram_rdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // capacity in use is the smaller of the register and the built depth
  assign cnt_ext = CMP_W'(count_r);
  assign max_ext = CMP_W'(max_entries_r);
  assign cap     = (max_ext < DEPTH_C) ? max_ext : DEPTH_C;
  assign full    = (cnt_ext >= cap);

  assign key_ext  = {16'd0, in_tdata[66:51]};
  assign rpos_ext = 32'(ram_rentry.pos);
  assign count_m1 = count_r - 1'b1;

  kslt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kslt_match u_match (
    .op    (op_r),
    .grp   (grp_r),
    .nam   (nam_r),
    .pos   (pos_r),
    .entry (ram_rentry),
    .hit   (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    ev_idx_nxt     = ev_idx_r;
    op_nxt         = op_r;
    grp_nxt        = grp_r;
    nam_nxt        = nam_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    rpos_nxt       = rpos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = ev_idx_r;
    ram_wdata      = ram_rentry;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_tdata[2:0];
          grp_nxt    = in_tdata[26:3];
          nam_nxt    = in_tdata[50:27];
          pos_nxt    = key_ext[POS_BITS-1:0];
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          status_nxt = STS_OK;
          rpos_nxt   = '0;
          if (in_tdata[2:0] == OP_CLEAR) begin
            state_nxt = ST_CL_RD;
          end else if (in_tdata[2:0] == OP_ADD || in_tdata[2:0] == OP_ACQUIRE ||
                       in_tdata[2:0] == OP_RELEASE || in_tdata[2:0] == OP_UNLOCK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      ST_SCAN: begin
        if (pend_r && hit) begin
          state_nxt = ST_OUT;
          case (op_r)
            OP_ACQUIRE: begin
              ram_we         = 1'b1;
              ram_wdata.lock = 1'b1;
              rpos_nxt       = rpos_ext[KEY_W-1:0];
            end
            OP_RELEASE: begin
              ram_we         = 1'b1;
              ram_wdata.lock = 1'b0;
            end
            default: status_nxt = STS_DUP;
          endcase
        end else if (!pend_r && idx_r >= count_r) begin
          // walked off the end without a hit
          state_nxt = ST_OUT;
          case (op_r)
            OP_ADD: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[ADDR_W-1:0];
                ram_wdata = '{lock: 1'b0, grp: grp_r, nam: nam_r, pos: pos_r};
                count_nxt = count_r + 1'b1;
              end
            end
            OP_ACQUIRE: status_nxt = STS_NONE;
            OP_RELEASE: status_nxt = STS_NOT_FOUND;
            default:    status_nxt = STS_OK;
          endcase
        end else begin
          if (pend_r && op_r == OP_UNLOCK) begin
            ram_we         = 1'b1;
            ram_wdata.lock = 1'b0;
          end
          // keep the read one place ahead of the compare
          if (idx_r < count_r) begin
            ram_re     = 1'b1;
            idx_nxt    = idx_r + 1'b1;
            ev_idx_nxt = idx_r[ADDR_W-1:0];
            pend_nxt   = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end

      ST_CL_RD: begin
        if (idx_r >= count_r) begin
          state_nxt = ST_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_CL_EV;
        end
      end

      ST_CL_EV: begin
        if (ram_rentry.lock) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_CL_RD;
        end else if (idx_r == count_m1) begin
          count_nxt = count_m1;
          state_nxt = ST_CL_RD;
        end else begin
          // fetch the last live entry to fill the freed place
          ram_re    = 1'b1;
          ram_raddr = count_m1[ADDR_W-1:0];
          state_nxt = ST_CL_MV;
        end
      end

      ST_CL_MV: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        count_nxt = count_m1;
        state_nxt = ST_CL_RD;
      end

      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({EC_W'(count_r), rpos_r, status_r});
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      pend_r        <= 1'b0;
      out_tvalid_r  <= 1'b0;
      max_entries_r <= MAX_ENTRIES_RST;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        max_entries_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    ev_idx_r    <= ev_idx_nxt;
    op_r        <= op_nxt;
    grp_r       <= grp_nxt;
    nam_r       <= nam_nxt;
    pos_r       <= pos_nxt;
    status_r    <= status_nxt;
    rpos_r      <= rpos_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

FILE: bench/kslt_checker.sv
// scoreboard for the keyed slot lock table: watches the request, result and
// register ports, predicts every result and compares it field by field
// depends on kslt_pkg
module kslt_table_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [kslt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [kslt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [kslt_pkg::CFG_W-1:0]       cfg_wr_data,
  output int                               n_waiting,
  output int                               n_errors
);
  import kslt_pkg::*;

  // request layout on in_tdata, lowest field last
  typedef struct packed {
    logic [IN_TDATA_W-OP_W-2*ID_W-KEY_W-1:0] pad;
    logic [KEY_W-1:0]                        key;
    logic [ID_W-1:0]                         nam;
    logic [ID_W-1:0]                         grp;
    logic [OP_W-1:0]                         op;
  } lock_req_t;

  // result layout on out_tdata
  typedef struct packed {
    logic [OUT_TDATA_W-EC_W-KEY_W-STS_W-1:0] pad;
    logic [EC_W-1:0]                         count;
    logic [KEY_W-1:0]                        pos;
    logic [STS_W-1:0]                        status;
  } lock_reply_t;

  entry_t           slots [DEPTH];
  int unsigned      live;
  logic [CFG_W-1:0] max_entries;
  lock_reply_t      pending_replies [$];

  initial begin
    n_errors  = 0;
    n_waiting = 0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    n_errors++;
  endtask

  // applies one request to the shadow table and returns the result it gives
  function automatic lock_reply_t table_reply(input lock_req_t req);
    lock_reply_t r;
    int unsigned lim;
    int unsigned i;
    bit          hit;
    r      = '0;
    r.status = STS_OK;
    lim    = (max_entries < DEPTH) ? max_entries : DEPTH;
    hit    = 1'b0;
    case (req.op)
      OP_ADD: begin
        for (i = 0; i < live; i++)
          if (slots[i].grp == req.grp && slots[i].nam == req.nam && slots[i].pos == req.key)
            hit = 1'b1;
        if (hit) begin
          r.status = STS_DUP;
        end else if (live >= lim) begin
          r.status = STS_FULL;
        end else begin
          slots[live].grp  = req.grp;
          slots[live].nam  = req.nam;
          slots[live].pos  = req.key;
          slots[live].lock = 1'b0;
          live++;
        end
      end
      OP_ACQUIRE: begin
        for (i = 0; i < live; i++)
          if (!hit && slots[i].grp == req.grp && slots[i].nam == req.nam && !slots[i].lock) begin
            slots[i].lock = 1'b1;
            r.pos = slots[i].pos;
            hit   = 1'b1;
          end
        if (!hit) r.status = STS_NONE;
      end
      OP_RELEASE: begin
        for (i = 0; i < live; i++)
          if (!hit && slots[i].grp == req.grp && slots[i].nam == req.nam &&
              slots[i].pos == req.key) begin
            slots[i].lock = 1'b0;
            hit = 1'b1;
          end
        if (!hit) r.status = STS_NOT_FOUND;
      end
      OP_UNLOCK: begin
        for (i = 0; i < live; i++) slots[i].lock = 1'b0;
      end
      OP_CLEAR: begin
        // freed place takes the last live entry, which is looked at next
        i = 0;
        while (i < live) begin
          if (slots[i].lock) begin
            i++;
          end else begin
            slots[i] = slots[live-1];
            live--;
          end
        end
      end
      default: ;
    endcase
    r.count = live[EC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lock_reply_t got;
    lock_reply_t want;
    if (!rst_n) begin
      live        = 0;
      max_entries = MAX_ENTRIES_RST;
      pending_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_replies.size() == 0) begin
          report("unexpected result", got, '0);
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.pos !== want.pos)
            report("result_pos", 32'(got.pos), 32'(want.pos));
          if (got.count !== want.count)
            report("entry_count", 32'(got.count), 32'(want.count));
          if (got.pad !== '0) report("tdata padding", 32'(got.pad), '0);
        end
      end
      if (cfg_wr_en) max_entries = cfg_wr_data;
      if (in_tvalid && in_tready) pending_replies.push_back(table_reply(in_tdata));
    end
    n_waiting <= pending_replies.size();
  end

endmodule

FILE: bench/tb_keyed_slot_lock_table.sv
// top of the keyed slot lock table bench: clock, reset, request and result
// traffic, register writes and the verdict; checking lives in kslt_table_checker
// depends on kslt_pkg, kslt_table_checker and the keyed_slot_lock_table rtl
module tb_keyed_slot_lock_table;
  import kslt_pkg::*;

  localparam int STALL_LIMIT = 4000;
  // first of the opcodes that the block leaves unassigned
  localparam logic [OP_W-1:0] OP_SPARE = 3'd5;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  int n_waiting;
  int n_errors;
  int n_taken = 0;
  bit calm    = 1'b0;

  logic [ID_W-1:0]  grp_pool [4];
  logic [ID_W-1:0]  nam_pool [3];
  logic [KEY_W-1:0] key_pool [12];

  keyed_slot_lock_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  kslt_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .n_waiting   (n_waiting),
    .n_errors    (n_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) n_taken <= n_taken + 1;
  end

  // puts one request on the bus and returns at the edge that takes it
  task automatic offer(input logic [OP_W-1:0] op, input logic [ID_W-1:0] grp,
                       input logic [ID_W-1:0] nam, input logic [KEY_W-1:0] key);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W-OP_W-2*ID_W-KEY_W){1'b0}}, key, nam, grp, op};
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
  endtask

  // register write once every outstanding result is back
  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    in_tvalid <= 1'b0;
    @(posedge clk iff (n_waiting == 0));
    cfg_wr_data <= cap;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item(input int add_pct);
    logic [OP_W-1:0]  op;
    logic [OP_W-1:0]  spare_ofs;
    logic [ID_W-1:0]  grp;
    logic [ID_W-1:0]  nam;
    logic [KEY_W-1:0] key;
    int               r;
    spare_ofs = OP_W'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      op = OP_ADD;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_ACQUIRE;
      else if (r < 72) op = OP_RELEASE;
      else if (r < 82) op = OP_UNLOCK;
      else if (r < 92) op = OP_CLEAR;
      else op = OP_SPARE + spare_ofs;
    end
    // mostly keys from the shared pools so that lookups hit, some pure noise
    if ($urandom_range(0, 11) == 0) begin
      grp = ID_W'($urandom);
      nam = ID_W'($urandom);
      key = KEY_W'($urandom);
    end else begin
      grp = grp_pool[$urandom_range(0, 3)];
      nam = nam_pool[$urandom_range(0, 2)];
      key = key_pool[$urandom_range(0, 11)];
    end
    offer(op, grp, nam, key);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int n_items, input int add_pct,
                           input bit fill);
    set_capacity(cap);
    // distinct keys, enough to run the table past its full depth
    if (fill)
      for (int i = 0; i < 70; i++)
        offer(OP_ADD, grp_pool[i % 4], nam_pool[(i / 4) % 3], key_pool[i / 12]);
    repeat (n_items) random_item(add_pct);
  endtask

  initial begin : sink
    bit held;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && n_taken >= 180) begin
        // long hold-off so that the block backs up onto its input
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        still = 0;
      else
        still++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    grp_pool[0] = "G01";
    grp_pool[1] = 24'hFFFFFF;
    grp_pool[2] = ID_W'($urandom);
    grp_pool[3] = ID_W'($urandom);
    nam_pool[0] = "KEK";
    nam_pool[1] = 24'h000000;
    nam_pool[2] = ID_W'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = KEY_W'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, lock and release corners
    offer(OP_ACQUIRE, "G01", "KEK", 16'd0);
    offer(OP_RELEASE, "G01", "KEK", 16'd5);
    offer(OP_UNLOCK, 24'h0, 24'h0, 16'd0);
    offer(OP_CLEAR, 24'h0, 24'h0, 16'd0);
    offer(OP_ADD, 24'h000000, 24'h000000, 16'h0000);
    offer(OP_ADD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    offer(OP_ADD, 24'h000000, 24'h000000, 16'h0000);
    offer(OP_ADD, "G01", "KEK", 16'd1);
    offer(OP_ADD, "G01", "KEK", 16'd2);
    offer(OP_ACQUIRE, "G01", "KEK", 16'd0);
    offer(OP_ACQUIRE, "G01", "KEK", 16'd0);
    offer(OP_ACQUIRE, "G01", "KEK", 16'd0);
    offer(OP_RELEASE, "G01", "KEK", 16'd1);
    offer(OP_RELEASE, "G01", "KEK", 16'd1);    // already unlocked
    offer(OP_RELEASE, "G01", "KEK", 16'd3);
    offer(OP_ACQUIRE, 24'hFFFFFF, 24'hFFFFFF, 16'd0);
    offer(OP_ACQUIRE, 24'h000000, 24'h000000, 16'hFFFF);
    offer(OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    offer(OP_SPARE, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    offer(OP_SPARE + 3'd1, 24'h0, 24'h0, 16'h0);
    offer(OP_SPARE + 3'd2, "G01", "KEK", 16'd1);
    offer(OP_UNLOCK, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    offer(OP_CLEAR, 24'h0, 24'h0, 16'h0);

    run_phase(7'd0, 20, 50, 1'b0);
    run_phase(7'd1, 30, 40, 1'b0);
    run_phase(7'd127, 60, 80, 1'b1);
    run_phase(7'd3, 40, 30, 1'b0);    // capacity now under the entry count
    run_phase(7'd64, 100, 45, 1'b0);
    run_phase(7'd8, 60, 40, 1'b0);
    run_phase(7'd2, 40, 40, 1'b0);
    calm = 1'b1;
    run_phase(7'd64, 100, 35, 1'b0);

    in_tvalid <= 1'b0;
    @(posedge clk iff (n_waiting == 0));
    repeat (20) @(posedge clk);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/kslt_pkg.sv
src/kslt_ram.sv
src/kslt_match.sv
src/keyed_slot_lock_table.sv
bench/kslt_checker.sv
bench/tb_keyed_slot_lock_table.sv
